>>> hw/rtl/positional_list_engine_macros.svh
// Assertion helpers used by the list engine datapath.
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

// Check that cond holds in the same cycle as trig.
`define PLE_ASSERT_SAME(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error(msg);

// Check that cond holds in the cycle after trig.
`define PLE_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

>>> hw/rtl/ple_pkg.sv
package ple_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int POS_W    = 16;

  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_FIND   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ADDR_CNT    = 2'd0,
    ADDR_CNT_M1 = 2'd1,
    ADDR_CNT_P1 = 2'd2
  } addr_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SHIFT,
    S_SHIFT_WR,
    S_DEL_CAP,
    S_MOVE,
    S_MOVE_WR,
    S_FIND,
    S_FIND_CMP,
    S_DONE
  } state_t;

  typedef struct packed {
    req_t                    req_type;
    logic signed [VAL_W-1:0] item_value;
    logic [POS_W-1:0]        position;
  } in_item_t;

  typedef struct packed {
    status_t                 status;
    logic signed [VAL_W-1:0] removed_value;
    logic [CNT_W-1:0]        found_position;
    logic [CNT_W-1:0]        entry_count;
  } out_result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      load;
    logic      rd_en;
    addr_sel_t rd_sel;
    logic      wr_en;
    logic      wr_item;
    logic      cnt_inc;
    logic      cnt_dec;
    logic      len_inc;
    logic      len_dec;
    logic      cap_removed;
    logic      set_found;
    logic      set_stat;
    status_t   stat;
  } ple_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    req_t req;
    logic len_zero;
    logic full;
    logic del_pos_ok;
    logic shift_more;
    logic move_more;
    logic find_more;
    logic match;
  } ple_flags_t;

endpackage

>>> hw/rtl/ple_ctrl.sv
module ple_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  ple_pkg::ple_flags_t flags,
  output ple_pkg::ple_cmd_t   cmd,
  output logic                busy,
  output logic                done
);
  import ple_pkg::*;

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.rd_sel = ADDR_CNT;
    cmd.stat   = ST_OK;
    busy      = 1'b1;
    done      = 1'b0;
    case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (flags.req)
          REQ_APPEND: begin
            if (flags.full) begin
              cmd.set_stat = 1'b1;
              cmd.stat     = ST_FULL;
              state_nxt    = S_DONE;
            end else begin
              state_nxt = S_SHIFT;
            end
          end
          REQ_INSERT: begin
            if (flags.len_zero) begin
              cmd.set_stat = 1'b1;
              cmd.stat     = ST_EMPTY;
              state_nxt    = S_DONE;
            end else if (flags.full) begin
              cmd.set_stat = 1'b1;
              cmd.stat     = ST_FULL;
              state_nxt    = S_DONE;
            end else begin
              state_nxt = S_SHIFT;
            end
          end
          REQ_DELETE: begin
            if (flags.len_zero) begin
              cmd.set_stat = 1'b1;
              cmd.stat     = ST_EMPTY;
              state_nxt    = S_DONE;
            end else if (!flags.del_pos_ok) begin
              cmd.set_stat = 1'b1;
              cmd.stat     = ST_BADPOS;
              state_nxt    = S_DONE;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = ADDR_CNT;
              state_nxt  = S_DEL_CAP;
            end
          end
          default: begin
            state_nxt = S_FIND;
          end
        endcase
      end
      // Open a hole at the target by moving entries up one place, then write the new item
      S_SHIFT: begin
        if (flags.shift_more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ADDR_CNT_M1;
          state_nxt  = S_SHIFT_WR;
        end else begin
          cmd.wr_en    = 1'b1;
          cmd.wr_item  = 1'b1;
          cmd.len_inc  = 1'b1;
          cmd.set_stat = 1'b1;
          cmd.stat     = ST_OK;
          state_nxt    = S_DONE;
        end
      end
      S_SHIFT_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.cnt_dec = 1'b1;
        state_nxt   = S_SHIFT;
      end
      S_DEL_CAP: begin
        cmd.cap_removed = 1'b1;
        state_nxt       = S_MOVE;
      end
      // Close the gap by moving entries down one place
      S_MOVE: begin
        if (flags.move_more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ADDR_CNT_P1;
          state_nxt  = S_MOVE_WR;
        end else begin
          cmd.len_dec  = 1'b1;
          cmd.set_stat = 1'b1;
          cmd.stat     = ST_OK;
          state_nxt    = S_DONE;
        end
      end
      S_MOVE_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.cnt_inc = 1'b1;
        state_nxt   = S_MOVE;
      end
      // Scan from the head for the first match
      S_FIND: begin
        if (flags.find_more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ADDR_CNT;
          state_nxt  = S_FIND_CMP;
        end else begin
          cmd.set_stat = 1'b1;
          cmd.stat     = ST_BADPOS;
          state_nxt    = S_DONE;
        end
      end
      S_FIND_CMP: begin
        if (flags.match) begin
          cmd.set_found = 1'b1;
          cmd.set_stat  = 1'b1;
          cmd.stat      = ST_OK;
          state_nxt     = S_DONE;
        end else begin
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_FIND;
        end
      end
      S_DONE: begin
        done      = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/ple_dpath.sv
`include "positional_list_engine_macros.svh"

module ple_dpath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ple_pkg::in_item_t    in_item,
  input  ple_pkg::ple_cmd_t    cmd,
  output ple_pkg::ple_flags_t  flags,
  output ple_pkg::out_result_t result
);
  import ple_pkg::*;

  logic [VAL_W-1:0] mem [CAPACITY];
  logic [VAL_W-1:0] rdata_r;

  req_t             req_r;
  logic [VAL_W-1:0] val_r;
  logic [POS_W-1:0] pos_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] tgt_r, tgt_nxt;
  logic [CNT_W-1:0] len_r, len_nxt;
  status_t          stat_r;
  logic [VAL_W-1:0] removed_r;
  logic [CNT_W-1:0] found_r;

  logic [POS_W:0]   len_p1_ext;
  logic [POS_W-1:0] in_pos_m1;
  logic             ins_ok;
  logic [IDX_W-1:0] rd_addr;
  logic [CNT_W-1:0] cnt_p1;
  logic [CNT_W-1:0] cnt_m1;

  assign cnt_p1 = cnt_r + CNT_W'(1);
  assign cnt_m1 = cnt_r - CNT_W'(1);

  // Position checks
  assign len_p1_ext = (POS_W+1)'(len_r) + (POS_W+1)'(1);
  assign in_pos_m1  = in_item.position - POS_W'(1);
  assign ins_ok     = (in_item.position != '0) &&
                      ({1'b0, in_item.position} <= len_p1_ext);

  assign flags.req        = req_r;
  assign flags.len_zero   = (len_r == '0);
  assign flags.full       = (len_r == CNT_W'(CAPACITY));
  assign flags.del_pos_ok = (pos_r != '0) && ({1'b0, pos_r} <= (POS_W+1)'(len_r));
  assign flags.shift_more = (cnt_r > tgt_r);
  assign flags.move_more  = (cnt_p1 < len_r);
  assign flags.find_more  = (cnt_r < len_r);
  assign flags.match      = (rdata_r == val_r);

  // Load target index and walk counter for the new request, or step the walk counter
  always_comb begin
    tgt_nxt = tgt_r;
    cnt_nxt = cnt_r;
    if (cmd.load) begin
      case (in_item.req_type)
        REQ_APPEND: begin
          tgt_nxt = len_r;
          cnt_nxt = len_r;
        end
        REQ_INSERT: begin
          tgt_nxt = ins_ok ? in_pos_m1[CNT_W-1:0] : len_r;
          cnt_nxt = len_r;
        end
        REQ_DELETE: begin
          tgt_nxt = in_pos_m1[CNT_W-1:0];
          cnt_nxt = in_pos_m1[CNT_W-1:0];
        end
        default: begin
          tgt_nxt = '0;
          cnt_nxt = '0;
        end
      endcase
    end else if (cmd.cnt_inc) begin
      cnt_nxt = cnt_p1;
    end else if (cmd.cnt_dec) begin
      cnt_nxt = cnt_m1;
    end
  end

  // Step the entry count up or down
  always_comb begin
    len_nxt = len_r;
    if (cmd.len_inc) begin
      len_nxt = len_r + CNT_W'(1);
    end else if (cmd.len_dec) begin
      len_nxt = len_r - CNT_W'(1);
    end
  end

  // Read address select
  always_comb begin
    case (cmd.rd_sel)
      ADDR_CNT_M1: rd_addr = cnt_m1[IDX_W-1:0];
      ADDR_CNT_P1: rd_addr = cnt_p1[IDX_W-1:0];
      default:     rd_addr = cnt_r[IDX_W-1:0];
    endcase
  end

  // List storage
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cnt_r[IDX_W-1:0]] <= cmd.wr_item ? val_r : rdata_r;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else begin
      len_r <= len_nxt;
    end
  end

  // Request and result registers
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    tgt_r <= tgt_nxt;
    if (cmd.load) begin
      req_r     <= in_item.req_type;
      val_r     <= in_item.item_value;
      pos_r     <= in_item.position;
      removed_r <= '0;
      found_r   <= '0;
    end
    if (cmd.cap_removed) begin
      removed_r <= rdata_r;
    end
    if (cmd.set_found) begin
      found_r <= cnt_p1;
    end
    if (cmd.set_stat) begin
      stat_r <= cmd.stat;
    end
  end

  assign result.status         = stat_r;
  assign result.removed_value  = removed_r;
  assign result.found_position = found_r;
  assign result.entry_count    = len_r;

  `PLE_ASSERT_SAME(a_len_bound, 1'b1, len_r <= CNT_W'(CAPACITY), "entry count over capacity")
  `PLE_ASSERT_NEXT(a_len_hold, !cmd.len_inc && !cmd.len_dec, $stable(len_r), "count moved unasked")
  `PLE_ASSERT_SAME(a_wr_range, cmd.wr_en, cnt_r < CNT_W'(CAPACITY), "write past storage")

endmodule

>>> hw/rtl/positional_list_engine.sv
// Each request is decoded; then append and insert move entries up one place and write
// the item, delete captures the removed entry and moves the rest down, and find scans
// from the head. One transaction at a time; start is taken in the cycle after the result
// strobe. Each entry moved or scanned takes a read state, then a write or compare state.
// Reset (synchronous, active low) empties the list; stored values stay undefined.
// The result is shown for one cycle on out_valid; the receiver cannot stall it.
module positional_list_engine (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  ple_pkg::in_item_t    in_item,
  output logic                 out_valid,
  output ple_pkg::out_result_t out_result
);
  import ple_pkg::*;

  ple_cmd_t   cmd;
  ple_flags_t flags;

  ple_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .flags (flags),
    .cmd   (cmd),
    .busy  (busy),
    .done  (out_valid)
  );

  ple_dpath u_dpath (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_item (in_item),
    .cmd     (cmd),
    .flags   (flags),
    .result  (out_result)
  );

endmodule

>>> tb/tb_positional_list_engine.sv
`timescale 1ns / 1ps

module tb_positional_list_engine;
  import ple_pkg::*;

  // Request stream shaping
  typedef enum int {
    MIX_GROW,
    MIX_SHRINK,
    MIX_EVEN
  } op_mix_t;

  typedef struct {
    in_item_t item;
    bit       drain_first;
  } pending_req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_item_t    in_item = '0;
  logic        out_valid;
  out_result_t out_result;

  pending_req_t pending_reqs[$];
  out_result_t  expected_replies[$];

  // Shadow list used to predict every reply
  logic signed [VAL_W-1:0] model_store [CAPACITY];
  int                      model_len = 0;

  // Entry count as seen by the stimulus generator
  int                      gen_len = 0;
  logic signed [VAL_W-1:0] value_pool [8];

  int idle_left = 0;
  int fault_count = 0;

  positional_list_engine u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

  always #4 clk = ~clk;

  // Apply one request to the shadow list and return the reply it should give
  function automatic out_result_t apply_request(in_item_t rq);
    out_result_t             r;
    int                      p;
    int                      k;
    bit                      hit;
    r = '0;
    r.status = ST_OK;
    p = int'(rq.position);
    hit = 1'b0;
    case (rq.req_type)
      REQ_APPEND: begin
        if (model_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          model_store[model_len] = rq.item_value;
          model_len++;
        end
      end
      REQ_INSERT: begin
        if (model_len == 0) begin
          r.status = ST_EMPTY;
        end else if (model_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          if (p < 1 || p > model_len + 1) p = model_len + 1;
          for (k = model_len; k > p - 1; k--) model_store[k] = model_store[k - 1];
          model_store[p - 1] = rq.item_value;
          model_len++;
        end
      end
      REQ_DELETE: begin
        if (model_len == 0) begin
          r.status = ST_EMPTY;
        end else if (p < 1 || p > model_len) begin
          r.status = ST_BADPOS;
        end else begin
          r.removed_value = model_store[p - 1];
          for (k = p - 1; k + 1 < model_len; k++) model_store[k] = model_store[k + 1];
          model_len--;
        end
      end
      REQ_FIND: begin
        r.status = ST_BADPOS;
        for (k = 0; k < model_len; k++) begin
          if (!hit && model_store[k] == rq.item_value) begin
            hit = 1'b1;
            r.found_position = CNT_W'(k + 1);
            r.status = ST_OK;
          end
        end
      end
      default: r.status = ST_BADPOS;
    endcase
    r.entry_count = CNT_W'(model_len);
    return r;
  endfunction

  // Queue one request and track the entry count it leaves behind
  task automatic add_req(req_t op, logic signed [VAL_W-1:0] v, int pos, bit drain);
    pending_req_t pr;
    pr.item.req_type   = op;
    pr.item.item_value = v;
    pr.item.position   = POS_W'(pos);
    pr.drain_first     = drain;
    pending_reqs.push_back(pr);
    case (op)
      REQ_APPEND: if (gen_len < CAPACITY) gen_len++;
      REQ_INSERT: if (gen_len > 0 && gen_len < CAPACITY) gen_len++;
      REQ_DELETE: if (gen_len > 0 && pos >= 1 && pos <= gen_len) gen_len--;
      default: ;
    endcase
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    if ($urandom_range(0, 1) == 0) return value_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  function automatic int pick_pos();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return int'($urandom_range(0, 65535));
      2: return gen_len + 1;
      3: return gen_len;
      default: return int'($urandom_range(1, (gen_len > 1) ? gen_len : 1));
    endcase
  endfunction

  // Drive requests: hold start until taken, insert random idle bursts
  always @(posedge clk) begin
    bit all_replied;
    bit idle_ok;
    if (!rst_n) begin
      start     <= 1'b0;
      in_item   <= '0;
      idle_left <= 0;
    end else begin
      if (start && !busy) expected_replies.push_back(apply_request(in_item));
      all_replied = (expected_replies.size() == 0) ||
                    (expected_replies.size() == 1 && out_valid);
      idle_ok = (pending_reqs.size() > 200) && ((pending_reqs.size() / 300) % 3 != 0);
      if (!start || !busy) begin
        if (idle_left != 0) begin
          start     <= 1'b0;
          idle_left <= idle_left - 1;
        end else if (pending_reqs.size() == 0) begin
          start <= 1'b0;
        end else if (pending_reqs[0].drain_first && !all_replied) begin
          start <= 1'b0;
        end else if (idle_ok && $urandom_range(0, 7) == 0) begin
          start     <= 1'b0;
          idle_left <= $urandom_range(0, 18);
        end else begin
          in_item <= pending_reqs[0].item;
          start   <= 1'b1;
          void'(pending_reqs.pop_front());
        end
      end
    end
  end

  // Check each reply against the oldest prediction
  always @(posedge clk) begin
    out_result_t want;
    if (rst_n && out_valid) begin
      if (expected_replies.size() == 0) begin
        if (fault_count < 10)
          $display("unexpected reply: status %0d removed %0d found %0d count %0d",
                   out_result.status, out_result.removed_value,
                   out_result.found_position, out_result.entry_count);
        fault_count++;
      end else begin
        want = expected_replies.pop_front();
        if (out_result.status !== want.status ||
            out_result.removed_value !== want.removed_value ||
            out_result.found_position !== want.found_position ||
            out_result.entry_count !== want.entry_count) begin
          if (fault_count < 10)
            $display("mismatch: status %0d/%0d removed %0d/%0d found %0d/%0d count %0d/%0d",
                     want.status, out_result.status,
                     want.removed_value, out_result.removed_value,
                     want.found_position, out_result.found_position,
                     want.entry_count, out_result.entry_count);
          fault_count++;
        end
      end
    end
  end

  // Build the stimulus, run it, then judge
  initial begin
    op_mix_t mix;
    int      ph;
    int      n;
    int      r;
    int      k;

    for (k = 0; k < CAPACITY; k++) model_store[k] = '0;
    value_pool[0] = 32'sh8000_0000;
    value_pool[1] = 32'sh7fff_ffff;
    value_pool[2] = 32'sd0;
    value_pool[3] = -32'sd1;
    for (k = 4; k < 8; k++) value_pool[k] = $urandom;

    // Directed: empty list cases, extremes, head/tail/middle, bad positions
    add_req(REQ_FIND,   32'sd5, 0, 1'b0);
    add_req(REQ_DELETE, 32'sd0, 1, 1'b0);
    add_req(REQ_INSERT, 32'sd9, 1, 1'b0);
    add_req(REQ_APPEND, 32'sh8000_0000, 0, 1'b0);
    add_req(REQ_DELETE, 32'sd0, 1, 1'b0);
    add_req(REQ_APPEND, 32'sh8000_0000, 65535, 1'b0);
    add_req(REQ_APPEND, 32'sh7fff_ffff, 0, 1'b0);
    add_req(REQ_INSERT, 32'sd0, 1, 1'b0);
    add_req(REQ_INSERT, -32'sd1, 0, 1'b0);
    add_req(REQ_INSERT, 32'sd123, gen_len + 1, 1'b0);
    add_req(REQ_INSERT, 32'sd7, 65535, 1'b0);
    add_req(REQ_INSERT, 32'sd7, 2, 1'b0);
    add_req(REQ_FIND,   32'sd7, 0, 1'b0);
    add_req(REQ_FIND,   32'sh7fff_ffff, 65535, 1'b0);
    add_req(REQ_FIND,   32'sd999, 0, 1'b0);
    add_req(REQ_DELETE, 32'sd0, 0, 1'b0);
    add_req(REQ_DELETE, 32'sd0, gen_len + 1, 1'b0);
    add_req(REQ_DELETE, 32'sd0, 65535, 1'b0);
    add_req(REQ_DELETE, 32'sd0, gen_len, 1'b0);
    add_req(REQ_DELETE, 32'sd0, 2, 1'b0);
    add_req(REQ_FIND,   32'sh8000_0000, 0, 1'b0);
    add_req(REQ_DELETE, 32'sd0, 1, 1'b0);

    // Random: phases that fill to full, drain to empty, and churn
    for (ph = 0; ph < 8; ph++) begin
      case (ph % 3)
        0: mix = MIX_GROW;
        1: mix = MIX_SHRINK;
        default: mix = MIX_EVEN;
      endcase
      for (n = 0; n < 250; n++) begin
        r = $urandom_range(0, 99);
        case (mix)
          MIX_GROW:   r = (r < 40) ? 0 : (r < 75) ? 1 : (r < 85) ? 2 : 3;
          MIX_SHRINK: r = (r < 10) ? 0 : (r < 20) ? 1 : (r < 80) ? 2 : 3;
          default:    r = r / 25;
        endcase
        case (r)
          0: add_req(REQ_APPEND, pick_value(), int'($urandom_range(0, 65535)), n == 0);
          1: add_req(REQ_INSERT, pick_value(), pick_pos(), n == 0);
          2: add_req(REQ_DELETE, $urandom, pick_pos(), n == 0);
          default: add_req(REQ_FIND, pick_value(), int'($urandom_range(0, 65535)), n == 0);
        endcase
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for all requests to be taken, then for all replies
    @(posedge clk);
    while (pending_reqs.size() != 0 || start) @(posedge clk);
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (2 * CAPACITY + 16) @(posedge clk);

    if (fault_count == 0 && expected_replies.size() == 0) begin
      $display("tb_positional_list_engine passed");
    end else begin
      $display("tb_positional_list_engine failed");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #8_000_000;
    $display("tb_positional_list_engine failed");
    $finish;
  end

endmodule

>>> positional_list_engine.f
+incdir+hw/rtl
hw/rtl/ple_pkg.sv
hw/rtl/ple_ctrl.sv
hw/rtl/ple_dpath.sv
hw/rtl/positional_list_engine.sv
tb/tb_positional_list_engine.sv
